// ----- sv/pcpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared types, codes and defaults of the per-CPU page allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

  localparam int NUM_PAGE_SLOTS_DEF = 32768;
  localparam int NUM_CPUS_DEF       = 8;
  localparam int REF_WIDTH_DEF      = 16;

  localparam logic [15:0] NUM_PAGES_RST = 16'd32768;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  // operation codes
  localparam logic [2:0] OP_FREE    = 3'd0;
  localparam logic [2:0] OP_ALLOC   = 3'd1;
  localparam logic [2:0] OP_SHARE   = 3'd2;
  localparam logic [2:0] OP_RELEASE = 3'd3;
  localparam logic [2:0] OP_QUERY   = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_UNDER   = 3'd3;
  localparam logic [2:0] ST_OVER    = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [2:0]  cpu;
    logic [14:0] page;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [14:0] page_out;
    logic [15:0] free_count;
    logic [15:0] ref_count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;    // zero one reference count entry
    logic accept;   // capture request, read list head and count
    logic rd_page;  // read reference count and link of the page
    logic exec;     // update state, load response register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

// ----- sv/pcpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpa_ctrl
// Sequencer: clearing pass, request capture, page read, update and response.
// ----------------------------------------------------------------------------
module pcpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pcpa_pkg::cmd_t cmd,
  input  pcpa_pkg::sts_t sts
);
  import pcpa_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LIST  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_LIST;
        end
      end
      S_LIST: begin
        cmd.rd_page = 1'b1;
        state_next  = S_EXEC;
      end
      S_EXEC: begin
        // wait for the response slot to drain
        if (!rsp_valid || !rsp_stall) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign rsp_valid_next = cmd.exec ? 1'b1 : (rsp_valid && rsp_stall);
  assign req_stall      = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// ----- sv/pcpa_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpa_dp
// Datapath: free list heads and counts, link memory, reference counts.
// ----------------------------------------------------------------------------
module pcpa_dp #(
  parameter int NUM_PAGE_SLOTS = pcpa_pkg::NUM_PAGE_SLOTS_DEF,
  parameter int NUM_CPUS       = pcpa_pkg::NUM_CPUS_DEF,
  parameter int REF_WIDTH      = pcpa_pkg::REF_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  pcpa_pkg::cmd_t cmd,
  output pcpa_pkg::sts_t sts,
  input  logic           cfg_wr_en,
  input  logic [15:0]    cfg_wr_data,
  input  pcpa_pkg::req_t req,
  output pcpa_pkg::rsp_t rsp
);
  import pcpa_pkg::*;

  localparam int PAGE_IW = $clog2(NUM_PAGE_SLOTS);
  localparam int CPU_IW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam logic [REF_WIDTH-1:0] REF_MAX = {REF_WIDTH{1'b1}};

  // storage
  logic [PAGE_IW-1:0]   link_mem [NUM_PAGE_SLOTS];
  logic [REF_WIDTH-1:0] refs_mem [NUM_PAGE_SLOTS];
  logic [PAGE_IW-1:0]   head_mem [NUM_CPUS];
  logic [15:0]          cnt_mem  [NUM_CPUS];
  logic [NUM_CPUS-1:0]  cnt_vld;
  logic [NUM_CPUS-1:0]  nonempty;
  logic [15:0]          num_pages;
  logic [PAGE_IW-1:0]   clr_addr;

  // captured request and read data
  logic [2:0]           op_q;
  logic [CPU_IW-1:0]    c_q;
  logic [CPU_IW-1:0]    src_q;
  logic [14:0]          pg_q;
  logic                 pv_q;
  logic                 found_q;
  logic [PAGE_IW-1:0]   head_q;
  logic [15:0]          cnt_q;
  logic                 cvld_q;
  logic [PAGE_IW-1:0]   link_q;
  logic [REF_WIDTH-1:0] ref_q;
  logic [PAGE_IW-1:0]   p_q;

  // request decode
  logic [6:0]           cmod;
  logic [CPU_IW-1:0]    c_in;
  logic [CPU_IW-1:0]    first_idx;
  logic [CPU_IW-1:0]    src_in;
  logic                 any_ne;
  logic                 pg_valid;
  logic [31:0]          req_pg32;
  logic [31:0]          pg32;
  logic [PAGE_IW-1:0]   pg_addr;
  logic [PAGE_IW-1:0]   p_addr;

  // update
  logic [15:0]          cnt_cur;
  logic [2:0]           st;
  logic [14:0]          pout;
  logic [15:0]          fcnt;
  logic [REF_WIDTH-1:0] refc;
  logic                 ref_we;
  logic [REF_WIDTH-1:0] ref_wd;
  logic                 link_we;
  logic                 list_we;
  logic [CPU_IW-1:0]    list_idx;
  logic [PAGE_IW-1:0]   head_wd;
  logic [15:0]          cnt_wd;
  logic [31:0]          p32;
  logic [31:0]          r32;
  logic                 refs_we_any;
  logic [PAGE_IW-1:0]   refs_wa;
  logic [REF_WIDTH-1:0] refs_wd;

  // cpu index modulo NUM_CPUS by repeated subtraction (value below 8)
  always_comb begin
    cmod = {4'b0, req.cpu};
    for (int i = 0; i < 8; i++) begin
      if (cmod >= 7'(NUM_CPUS)) cmod = cmod - 7'(NUM_CPUS);
    end
    c_in = cmod[CPU_IW-1:0];
  end

  // lowest-numbered CPU with a listed page, the source of an ALLOC whose own list is empty
  always_comb begin
    first_idx = '0;
    for (int i = NUM_CPUS - 1; i >= 0; i--) begin
      if (nonempty[i]) first_idx = CPU_IW'(i);
    end
    any_ne = |nonempty;
    src_in = (req.operation == OP_ALLOC && !nonempty[c_in]) ? first_idx : c_in;
  end

  assign req_pg32 = 32'(req.page);
  assign pg_valid = ({1'b0, req.page} < num_pages) && (req_pg32 < 32'(NUM_PAGE_SLOTS));
  assign pg32     = 32'(pg_q);
  assign pg_addr  = pg32[PAGE_IW-1:0];
  assign p_addr   = (op_q == OP_ALLOC) ? head_q : pg_addr;

  assign sts.clear_last = (clr_addr == PAGE_IW'(NUM_PAGE_SLOTS - 1));

  // state update for the captured request
  always_comb begin
    cnt_cur  = cvld_q ? cnt_q : 16'd0;
    st       = ST_OK;
    pout     = '0;
    fcnt     = cnt_cur;
    refc     = '0;
    ref_we   = 1'b0;
    ref_wd   = ref_q;
    link_we  = 1'b0;
    list_we  = 1'b0;
    list_idx = c_q;
    head_wd  = p_q;
    cnt_wd   = cnt_cur + 16'd1;
    p32      = 32'(p_q);
    case (op_q)
      OP_FREE, OP_SHARE, OP_RELEASE: begin
        pout = pg_q;
        if (!pv_q) begin
          st = ST_INVALID;
        end else begin
          refc = ref_q;
          if (op_q == OP_FREE) begin
            if (cnt_cur == COUNT_MAX) begin
              st = ST_OVER;
            end else begin
              link_we = 1'b1;
              list_we = 1'b1;
              fcnt    = cnt_wd;
            end
          end else if (op_q == OP_SHARE) begin
            if (ref_q == REF_MAX) begin
              st = ST_OVER;
            end else begin
              ref_we = 1'b1;
              ref_wd = ref_q + 1'b1;
              refc   = ref_wd;
            end
          end else begin
            if (ref_q == '0) begin
              st = ST_UNDER;
            end else begin
              ref_we = 1'b1;
              ref_wd = ref_q - 1'b1;
              refc   = ref_wd;
              // last reference gone: the page goes back on the list unless its count is at COUNT_MAX
              if (ref_wd == '0) begin
                if (cnt_cur == COUNT_MAX) begin
                  st = ST_OVER;
                end else begin
                  link_we = 1'b1;
                  list_we = 1'b1;
                  fcnt    = cnt_wd;
                end
              end
            end
          end
        end
      end
      OP_ALLOC: begin
        fcnt = '0;
        if (!found_q) begin
          st = ST_EMPTY;
        end else begin
          list_we  = 1'b1;
          list_idx = src_q;
          head_wd  = link_q;
          cnt_wd   = cnt_cur - 16'd1;
          pout     = p32[14:0];
          if (src_q == c_q) fcnt = cnt_wd;
          if (ref_q == REF_MAX) begin
            st   = ST_OVER;
            refc = ref_q;
          end else begin
            ref_we = 1'b1;
            ref_wd = ref_q + 1'b1;
            refc   = ref_wd;
          end
        end
      end
      default: begin
        fcnt = cnt_cur;
      end
    endcase
    r32 = 32'(refc);
  end

  assign refs_we_any = cmd.clear || (cmd.exec && ref_we);
  assign refs_wa     = cmd.clear ? clr_addr : p_q;
  assign refs_wd     = cmd.clear ? '0 : ref_wd;

  // reference count memory
  always_ff @(posedge clk) begin
    if (refs_we_any) refs_mem[refs_wa] <= refs_wd;
    if (cmd.rd_page) ref_q <= refs_mem[p_addr];
  end

  // link memory
  always_ff @(posedge clk) begin
    if (cmd.exec && link_we) link_mem[p_q] <= head_q;
    if (cmd.rd_page) link_q <= link_mem[head_q];
  end

  // list heads and counts
  always_ff @(posedge clk) begin
    if (cmd.exec && list_we) begin
      head_mem[list_idx] <= head_wd;
      cnt_mem[list_idx]  <= cnt_wd;
    end
    if (cmd.accept) begin
      head_q <= head_mem[src_in];
      cnt_q  <= cnt_mem[src_in];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld   <= '0;
      nonempty  <= '0;
      num_pages <= NUM_PAGES_RST;
      clr_addr  <= '0;
    end else begin
      if (cmd.exec && list_we) begin
        cnt_vld[list_idx]  <= 1'b1;
        nonempty[list_idx] <= (cnt_wd != 16'd0);
      end
      if (cfg_wr_en) num_pages <= cfg_wr_data;
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
    end
  end

  // request capture, page address and response register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q    <= req.operation;
      c_q     <= c_in;
      src_q   <= src_in;
      pg_q    <= req.page;
      pv_q    <= pg_valid;
      found_q <= any_ne;
      cvld_q  <= cnt_vld[src_in];
    end
    if (cmd.rd_page) p_q <= p_addr;
    if (cmd.exec) begin
      rsp.status     <= st;
      rsp.page_out   <= pout;
      rsp.free_count <= fcnt;
      rsp.ref_count  <= r32[15:0];
    end
  end

endmodule

// ----- sv/per_cpu_page_allocator_refcount.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_cpu_page_allocator_refcount
// Per-CPU LIFO free lists of page indices with a reference count per page.
// ----------------------------------------------------------------------------
// Request channel: req_valid / req_stall / req (operation, cpu, page). A
// transaction completes on a clock edge with req_valid high and req_stall low.
// Response channel: rsp_valid / rsp_stall / rsp (status, page_out, free_count,
// ref_count); one response per request, in request order.
// Configuration: cfg_wr_en / cfg_wr_data write num_pages; write only while idle.
//
// Each request passes through a list head and count read, a page reference
// count and link read, then the update with the response registered. A new
// request is accepted only after the previous one has finished its update;
// the two dependent registered memory reads set the pace.
// The response register lets the next request be accepted while a response
// waits; a stalled receiver holds a finished request in its update step.
//
// After reset the reference counts are zeroed one entry per cycle over all
// NUM_PAGE_SLOTS entries; req_stall stays high during that pass.
// ----------------------------------------------------------------------------
module per_cpu_page_allocator_refcount #(
  parameter int NUM_PAGE_SLOTS = pcpa_pkg::NUM_PAGE_SLOTS_DEF,
  parameter int NUM_CPUS       = pcpa_pkg::NUM_CPUS_DEF,
  parameter int REF_WIDTH      = pcpa_pkg::REF_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  pcpa_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output pcpa_pkg::rsp_t rsp,
  input  logic           cfg_wr_en,
  input  logic [15:0]    cfg_wr_data
);
  import pcpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pcpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  pcpa_dp #(
    .NUM_PAGE_SLOTS (NUM_PAGE_SLOTS),
    .NUM_CPUS       (NUM_CPUS),
    .REF_WIDTH      (REF_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .rsp         (rsp)
  );

endmodule

// ----- sv/pcpa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpa_checker
// Port-level checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pcpa_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input pcpa_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input pcpa_pkg::rsp_t rsp
);
  import pcpa_pkg::*;

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // clearing pass keeps requests off right after reset
  a_reset_stall: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request side open during clearing pass");

  // one request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted back to back");

  // a fresh response traces back to an accepted request
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && !req_stall, 3))
    else $error("response without matching request");

endmodule

bind per_cpu_page_allocator_refcount pcpa_checker u_pcpa_checker (.*);
